// ===== sv/ps2s1_pkg.sv =====
`timescale 1ns / 1ps

package ps2s1_pkg;

	localparam int MAX_EVENTS   = 64;
	localparam int KEY_MAP_SIZE = 128;
	localparam int CNT_W        = $clog2(MAX_EVENTS + 1);

	localparam logic [6:0] KEY_LSHIFT  = 7'h2A;
	localparam logic [6:0] KEY_RSHIFT  = 7'h36;
	localparam logic [6:0] KEY_CAPS    = 7'h3A;
	localparam int         RELEASE_BIT = 7;

	typedef enum logic [1:0] {
		KIND_SCAN  = 2'd0,
		KIND_CLEAR = 2'd1,
		KIND_QUERY = 2'd2
	} kind_t;

	// one write into the key-down map
	typedef struct packed {
		logic       en;
		logic [6:0] key;
		logic       down;
	} keymap_wr_t;

	typedef struct packed {
		logic       accepted;
		logic [7:0] event_scancode;
		logic [6:0] event_char;
		logic [5:0] event_slot;
		logic       key_down;
		logic       shift_held;
		logic       caps_on;
		logic [6:0] event_count;
	} result_t;

	function automatic logic [6:0] plain_char(input logic [6:0] key);
		logic [6:0] c;
		case (key)
			7'h02: c = 7'("1");
			7'h03: c = 7'("2");
			7'h04: c = 7'("3");
			7'h05: c = 7'("4");
			7'h06: c = 7'("5");
			7'h07: c = 7'("6");
			7'h08: c = 7'("7");
			7'h09: c = 7'("8");
			7'h0A: c = 7'("9");
			7'h0B: c = 7'("0");
			7'h0C: c = 7'("-");
			7'h0D: c = 7'("=");
			7'h0F: c = 7'("\t");
			7'h10: c = 7'("q");
			7'h11: c = 7'("w");
			7'h12: c = 7'("e");
			7'h13: c = 7'("r");
			7'h14: c = 7'("t");
			7'h15: c = 7'("y");
			7'h16: c = 7'("u");
			7'h17: c = 7'("i");
			7'h18: c = 7'("o");
			7'h19: c = 7'("p");
			7'h1A: c = 7'("[");
			7'h1B: c = 7'("]");
			7'h1C: c = 7'("\n");
			7'h1E: c = 7'("a");
			7'h1F: c = 7'("s");
			7'h20: c = 7'("d");
			7'h21: c = 7'("f");
			7'h22: c = 7'("g");
			7'h23: c = 7'("h");
			7'h24: c = 7'("j");
			7'h25: c = 7'("k");
			7'h26: c = 7'("l");
			7'h27: c = 7'(";");
			7'h28: c = 7'("'");
			7'h2B: c = 7'("\\");
			7'h2C: c = 7'("z");
			7'h2D: c = 7'("x");
			7'h2E: c = 7'("c");
			7'h2F: c = 7'("v");
			7'h30: c = 7'("b");
			7'h31: c = 7'("n");
			7'h32: c = 7'("m");
			7'h33: c = 7'(",");
			7'h34: c = 7'(".");
			7'h35: c = 7'("/");
			7'h39: c = 7'(" ");
			default: c = 7'd0;
		endcase
		return c;
	endfunction

	function automatic logic [6:0] shift_char(input logic [6:0] key);
		logic [6:0] c;
		case (key)
			7'h02: c = 7'("!");
			7'h03: c = 7'("@");
			7'h04: c = 7'("#");
			7'h05: c = 7'("$");
			7'h06: c = 7'("%");
			7'h07: c = 7'("^");
			7'h08: c = 7'("&");
			7'h09: c = 7'("*");
			7'h0A: c = 7'("(");
			7'h0B: c = 7'(")");
			7'h0C: c = 7'("_");
			7'h0D: c = 7'("+");
			7'h0F: c = 7'("\t");
			7'h10: c = 7'("Q");
			7'h11: c = 7'("W");
			7'h12: c = 7'("E");
			7'h13: c = 7'("R");
			7'h14: c = 7'("T");
			7'h15: c = 7'("Y");
			7'h16: c = 7'("U");
			7'h17: c = 7'("I");
			7'h18: c = 7'("O");
			7'h19: c = 7'("P");
			7'h1A: c = 7'("{");
			7'h1B: c = 7'("}");
			7'h1C: c = 7'("\n");
			7'h1E: c = 7'("A");
			7'h1F: c = 7'("S");
			7'h20: c = 7'("D");
			7'h21: c = 7'("F");
			7'h22: c = 7'("G");
			7'h23: c = 7'("H");
			7'h24: c = 7'("J");
			7'h25: c = 7'("K");
			7'h26: c = 7'("L");
			7'h27: c = 7'(":");
			7'h28: c = 7'("\"");
			7'h2B: c = 7'("|");
			7'h2C: c = 7'("Z");
			7'h2D: c = 7'("X");
			7'h2E: c = 7'("C");
			7'h2F: c = 7'("V");
			7'h30: c = 7'("B");
			7'h31: c = 7'("N");
			7'h32: c = 7'("M");
			7'h33: c = 7'("<");
			7'h34: c = 7'(">");
			7'h35: c = 7'("?");
			7'h39: c = 7'(" ");
			default: c = 7'd0;
		endcase
		return c;
	endfunction

endpackage

// ===== sv/ps2s1_if.sv =====
`timescale 1ns / 1ps

interface ps2s1_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic [7:0] data_byte;

	modport source (output valid, output kind, output data_byte, input ready);
	modport sink (input valid, input kind, input data_byte, output ready);
endinterface

interface ps2s1_out_if;
	logic       valid;
	logic       ready;
	logic       accepted;
	logic [7:0] event_scancode;
	logic [6:0] event_char;
	logic [5:0] event_slot;
	logic       key_down;
	logic       shift_held;
	logic       caps_on;
	logic [6:0] event_count;

	modport source (output valid, output accepted, output event_scancode, output event_char,
		output event_slot, output key_down, output shift_held, output caps_on,
		output event_count, input ready);
	modport sink (input valid, input accepted, input event_scancode, input event_char,
		input event_slot, input key_down, input shift_held, input caps_on,
		input event_count, output ready);
endinterface

// ===== sv/ps2_set1_scancode_to_ascii.sv =====
`timescale 1ns / 1ps

// PS/2 scan code set 1 to ASCII decoder. Each input transaction is a received scan
// byte, a clear of the event count, or a query of one key's held state; each one
// yields exactly one output transaction. A scan byte is taken as an event while
// fewer than MAX_EVENTS events are counted: it updates the key-down map, the shift
// and caps-lock flags, and reports the raw byte, its ASCII character (0 for
// releases, modifiers and unmapped keys) and its slot. At the limit the byte is
// dropped with accepted low until a clear. A transaction passes through the input
// register, then the result register; one transaction per cycle is sustained while
// the sink is ready, limited only by the single state update done between the two
// registers. The output register lets a new transaction enter while a finished
// result still waits for the sink. After reset the key-down map is cleared one
// key per cycle, so the input stays not ready until all 128 keys are cleared.

module ps2_set1_scancode_to_ascii (
	input  logic        clk,
	input  logic        arst_n,
	ps2s1_in_if.sink    in_ch,
	ps2s1_out_if.source out_ch
);

	// input stage
	logic       v_s1;
	logic [1:0] kind_s1;
	logic [7:0] data_s1;

	// result stage
	logic                v_s2;
	ps2s1_pkg::result_t  res_s2;

	// decoder state
	logic                        shift_q;
	logic                        caps_q;
	logic [ps2s1_pkg::CNT_W-1:0] cnt_q;

	logic                        adv;
	logic                        take_scan;
	logic [6:0]                  key;
	logic                        rel;
	logic                        is_shift;
	logic                        shift_nx;
	logic                        caps_nx;
	logic [ps2s1_pkg::CNT_W-1:0] cnt_nx;
	logic [6:0]                  ch;
	logic                        down;
	logic                        map_busy;
	ps2s1_pkg::keymap_wr_t       map_wr;
	ps2s1_pkg::result_t          res_nx;

	// advance the input stage whenever the result register is free or draining
	assign adv         = v_s1 && (!v_s2 || out_ch.ready);
	// hold off input while the key map is being cleared
	assign in_ch.ready = (!v_s1 || adv) && !map_busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			v_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			kind_s1 <= in_ch.kind;
			data_s1 <= in_ch.data_byte;
		end
	end

	assign key      = data_s1[6:0];
	assign rel      = data_s1[ps2s1_pkg::RELEASE_BIT];
	assign is_shift = (key == ps2s1_pkg::KEY_LSHIFT) || (key == ps2s1_pkg::KEY_RSHIFT);

	// a scan byte counts as an event only below the limit
	assign take_scan = (kind_s1 == ps2s1_pkg::KIND_SCAN)
		&& (int'(cnt_q) < ps2s1_pkg::MAX_EVENTS);

	ps2s1_char_lut u_lut (
		.key   (key),
		.shift (shift_q),
		.caps  (caps_q),
		.ch    (ch)
	);

	assign map_wr.en   = adv && take_scan;
	assign map_wr.key  = key;
	assign map_wr.down = !rel;

	// the map is read as the transaction enters the input register
	ps2s1_keymap u_map (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (map_wr),
		.rd_en   (in_ch.valid && in_ch.ready),
		.rd_key  (in_ch.data_byte),
		.rd_down (down),
		.busy    (map_busy)
	);

	always_comb begin
		shift_nx = shift_q;
		caps_nx  = caps_q;
		cnt_nx   = cnt_q;
		res_nx   = '0;
		case (kind_s1)
			ps2s1_pkg::KIND_SCAN: begin
				if (take_scan) begin
					res_nx.accepted       = 1'b1;
					res_nx.event_scancode = data_s1;
					res_nx.event_slot     = 6'(cnt_q);
					cnt_nx                = cnt_q + 1'b1;
					if (rel) begin
						// release: only shift keys change state
						if (is_shift) begin
							shift_nx = 1'b0;
						end
					end else if (key == ps2s1_pkg::KEY_CAPS) begin
						caps_nx = !caps_q;
					end else if (is_shift) begin
						shift_nx = 1'b1;
					end else begin
						res_nx.event_char = ch;
					end
				end
			end
			ps2s1_pkg::KIND_CLEAR: begin
				cnt_nx = '0;
			end
			ps2s1_pkg::KIND_QUERY: begin
				res_nx.key_down = down;
			end
			default: begin
				// unused kind: report state only
			end
		endcase
		res_nx.shift_held  = shift_nx;
		res_nx.caps_on     = caps_nx;
		res_nx.event_count = 7'(cnt_nx);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q <= 1'b0;
			caps_q  <= 1'b0;
			cnt_q   <= '0;
			v_s2    <= 1'b0;
		end else begin
			if (adv) begin
				shift_q <= shift_nx;
				caps_q  <= caps_nx;
				cnt_q   <= cnt_nx;
				v_s2    <= 1'b1;
			end else if (out_ch.ready) begin
				v_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2 <= res_nx;
		end
	end

	assign out_ch.valid          = v_s2;
	assign out_ch.accepted       = res_s2.accepted;
	assign out_ch.event_scancode = res_s2.event_scancode;
	assign out_ch.event_char     = res_s2.event_char;
	assign out_ch.event_slot     = res_s2.event_slot;
	assign out_ch.key_down       = res_s2.key_down;
	assign out_ch.shift_held     = res_s2.shift_held;
	assign out_ch.caps_on        = res_s2.caps_on;
	assign out_ch.event_count    = res_s2.event_count;

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		int'(cnt_q) <= ps2s1_pkg::MAX_EVENTS)
		else $error("event count above limit");

	a_cnt_step: assert property (@(posedge clk) disable iff (!arst_n)
		adv && take_scan |=> cnt_q == $past(cnt_q) + 1'b1)
		else $error("event count did not advance on a taken scan byte");

	a_shift_set: assert property (@(posedge clk) disable iff (!arst_n)
		adv && take_scan && !rel && is_shift |=> shift_q)
		else $error("shift press did not set shift");

	a_rel_nochar: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && res_s2.accepted && res_s2.event_scancode[7] |-> res_s2.event_char == 7'd0)
		else $error("release produced a character");

	a_drop_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && !res_s2.accepted |-> res_s2.event_scancode == 8'd0 && res_s2.event_slot == 6'd0)
		else $error("dropped item carries event fields");
`endif

endmodule

// ===== sv/ps2s1_char_lut.sv =====
`timescale 1ns / 1ps

module ps2s1_char_lut (
	input  logic [6:0] key,
	input  logic       shift,
	input  logic       caps,
	output logic [6:0] ch
);

	logic [6:0] lo;
	logic [6:0] hi;
	logic       letter;
	logic       upper;

	always_comb begin
		lo     = ps2s1_pkg::plain_char(key);
		hi     = ps2s1_pkg::shift_char(key);
		letter = lo inside {[7'("a"):7'("z")]};
		// caps lock only flips letters
		upper  = letter ? (shift ^ caps) : shift;
		ch     = upper ? hi : lo;
	end

endmodule

// ===== sv/ps2s1_keymap.sv =====
`timescale 1ns / 1ps

module ps2s1_keymap (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ps2s1_pkg::keymap_wr_t wr,
	input  logic                  rd_en,
	input  logic [7:0]            rd_key,
	output logic                  rd_down,
	output logic                  busy
);

	// key-down bits live in a RAM; after reset a clearing pass zeroes one entry per cycle
	logic       mem [ps2s1_pkg::KEY_MAP_SIZE];
	logic [6:0] clr_idx_q;
	logic       clr_q;
	logic       rd_q;
	logic       wr_ok;
	logic       wr_hit;

	assign wr_ok  = wr.en && (int'(wr.key) < ps2s1_pkg::KEY_MAP_SIZE);
	assign wr_hit = wr_ok && (wr.key == rd_key[6:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= 1'b1;
			clr_idx_q <= '0;
		end else if (clr_q) begin
			clr_idx_q <= clr_idx_q + 1'b1;
			if (clr_idx_q == 7'(ps2s1_pkg::KEY_MAP_SIZE - 1)) begin
				clr_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (clr_q) begin
			mem[clr_idx_q] <= 1'b0;
		end else if (wr_ok) begin
			mem[wr.key] <= wr.down;
		end
	end

	// registered read; forward a write to the same key at the same edge
	always_ff @(posedge clk) begin
		if (rd_en) begin
			if (int'(rd_key) >= ps2s1_pkg::KEY_MAP_SIZE) begin
				rd_q <= 1'b0;
			end else if (wr_hit) begin
				rd_q <= wr.down;
			end else begin
				rd_q <= mem[rd_key[6:0]];
			end
		end
	end

	assign rd_down = rd_q;
	assign busy    = clr_q;

endmodule
